// ----- hw/rtl/wsl_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// wsl_pkg
// Shared constants, types and coefficient table for the Wilson lower bound.
// ----------------------------------------------------------------------------
package wsl_pkg;

    localparam int COUNT_BITS_DEF = 24;
    localparam int FRAC_BITS_DEF  = 16;

    // z and z^2 are carried as unsigned Q8.24 in 32-bit words
    localparam int Z_FRAC = 24;
    localparam int ZW     = 32;

    localparam logic [15:0] ALPHA_RESET = 16'd3277;
    localparam logic [31:0] LN2_Q32     = 32'd2977044472;

    // inverse-normal polynomial, signed Q.48, constant term first
    localparam logic signed [63:0] POLY_Q48 [11] = '{
        64'sd442139848581985,
        64'sd10434243345080,
        -64'sd235435623166,
        -64'sd63358530394,
        64'sd1925631761,
        64'sd1639377400,
        -64'sd294218748,
        64'sd23533946,
        -64'sd909469,
        64'sd10296,
        64'sd195
    };

    typedef struct packed {
        logic          ok;   // z values settled for the current alpha
        logic [ZW-1:0] z2;   // z^2, Q8.24
        logic [ZW-1:0] zq;   // z,   Q8.24
    } t_z_info;

endpackage
`default_nettype wire

// ----- hw/rtl/wsl_if.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// wsl_in_if / wsl_out_if
// Valid/ready channels for count pairs in and bounds out.
// ----------------------------------------------------------------------------
interface wsl_in_if
    import wsl_pkg::*;
#(
    parameter int COUNT_BITS = COUNT_BITS_DEF
) ();
    logic                  valid;
    logic                  ready;
    logic [COUNT_BITS-1:0] positive_count;
    logic [COUNT_BITS-1:0] total_count;

    modport source (output valid, positive_count, total_count, input ready);
    modport sink   (input valid, positive_count, total_count, output ready);
endinterface

interface wsl_out_if
    import wsl_pkg::*;
#(
    parameter int FRAC_BITS = FRAC_BITS_DEF
) ();
    logic                 valid;
    logic                 ready;
    logic [FRAC_BITS:0]   lower_bound_q16;
    logic                 count_error;

    modport source (output valid, lower_bound_q16, count_error, input ready);
    modport sink   (input valid, lower_bound_q16, count_error, output ready);
endinterface
`default_nettype wire

// ----- hw/rtl/wsl_z_gen.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// wsl_z_gen
// Sequencer deriving z^2 and z from alpha: log2 by squaring, ln scale,
// Horner polynomial, then a bit-pair square root. A run is longer the
// more shifts 4q(1-q) needs to normalise.
// ----------------------------------------------------------------------------
module wsl_z_gen
    import wsl_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cfg_we,
    input  wire logic [15:0] i_cfg_data,
    output t_z_info          o_z
);

    typedef enum logic [3:0] {
        S_MULP, S_NORM, S_LOG, S_W3, S_POLYA, S_POLYB, S_ROOT0, S_ROOT, S_IDLE
    } t_state;

    t_state              r_state;
    logic [15:0]         r_alpha;
    logic [31:0]         r_p;
    logic [5:0]          r_k;
    logic [23:0]         r_frac;
    logic [4:0]          r_cnt;
    logic [3:0]          r_pcnt;
    logic [31:0]         r_w3;
    logic signed [63:0]  r_h;
    logic [63:0]         r_pa;
    logic [55:0]         r_pb;
    logic                r_neg;
    logic [63:0]         r_v;
    logic [63:0]         r_res;
    logic [63:0]         r_bit;
    logic [ZW-1:0]       r_z2;
    logic [ZW-1:0]       r_zq;

    logic [16:0]         a;
    logic [34:0]         p_full;
    logic [63:0]         xsq;
    logic [32:0]         y;
    logic [29:0]         base;
    logic [61:0]         w3_full;
    logic [63:0]         m;
    logic [63:0]         mul_r;
    logic signed [63:0]  mul_s;
    logic [63:0]         root_sum;

    always_comb begin
        a        = (r_alpha == 16'd0) ? 17'd1 : {1'b0, r_alpha};
        p_full   = 35'(a) * (35'd131072 - 35'(a));
        xsq      = 64'(r_p) * 64'(r_p);
        y        = xsq[63:31];
        base     = 30'((30'(r_k) + 30'd1) << 24) - 30'(r_frac);
        w3_full  = 62'(base) * 62'(LN2_Q32);
        m        = r_h[63] ? 64'(-r_h) : 64'(r_h);
        mul_r    = r_pa + 64'(r_pb >> 24);
        mul_s    = r_neg ? -$signed(mul_r) : $signed(mul_r);
        root_sum = r_res + r_bit;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_MULP;
            r_alpha <= ALPHA_RESET;
        end else if (i_cfg_we) begin
            r_alpha <= i_cfg_data;
            r_state <= S_MULP;
        end else begin
            unique case (r_state)
                S_MULP: begin
                    r_p     <= p_full[31:0];
                    r_k     <= '0;
                    r_state <= S_NORM;
                end
                S_NORM: begin
                    if (!r_p[31]) begin
                        r_p <= {r_p[30:0], 1'b0};
                        r_k <= r_k + 6'd1;
                    end else begin
                        r_cnt   <= 5'd23;
                        r_frac  <= '0;
                        r_state <= S_LOG;
                    end
                end
                S_LOG: begin
                    // mantissa squared; overflow past 2 yields one log2 bit
                    if (y[32]) begin
                        r_frac[r_cnt] <= 1'b1;
                        r_p           <= y[32:1];
                    end else begin
                        r_p <= y[31:0];
                    end
                    if (r_cnt == 5'd0) r_state <= S_W3;
                    else               r_cnt   <= r_cnt - 5'd1;
                end
                S_W3: begin
                    r_w3    <= 32'(w3_full[61:32]);
                    r_h     <= POLY_Q48[10];
                    r_pcnt  <= 4'd10;
                    r_state <= S_POLYA;
                end
                S_POLYA: begin
                    r_neg   <= r_h[63];
                    r_pa    <= 64'(m[55:24]) * 64'(r_w3);
                    r_pb    <= 56'(m[23:0]) * 56'(r_w3);
                    r_state <= S_POLYB;
                end
                S_POLYB: begin
                    if (r_pcnt != 4'd0) begin
                        r_h     <= POLY_Q48[r_pcnt - 4'd1] + mul_s;
                        r_pcnt  <= r_pcnt - 4'd1;
                        r_state <= S_POLYA;
                    end else begin
                        r_h     <= mul_s;
                        r_state <= S_ROOT0;
                    end
                end
                S_ROOT0: begin
                    // negative polynomial result clamps z to zero
                    r_z2    <= r_h[63] ? '0 : ZW'(r_h[55:24]);
                    r_v     <= r_h[63] ? '0 : {8'd0, r_h[55:24], 24'd0};
                    r_res   <= '0;
                    r_bit   <= 64'd1 << 62;
                    r_cnt   <= 5'd31;
                    r_state <= S_ROOT;
                end
                S_ROOT: begin
                    if (r_v >= root_sum) begin
                        r_v   <= r_v - root_sum;
                        r_res <= (r_res >> 1) + r_bit;
                    end else begin
                        r_res <= r_res >> 1;
                    end
                    r_bit <= r_bit >> 2;
                    if (r_cnt == 5'd0) r_state <= S_IDLE;
                    else               r_cnt   <= r_cnt - 5'd1;
                end
                S_IDLE: begin
                    r_zq <= ZW'(r_res);
                end
                default: r_state <= S_MULP;
            endcase
        end
    end

    // z is taken from r_res, which holds still once the root has finished
    assign o_z.ok = (r_state == S_IDLE);
    assign o_z.z2 = r_z2;
    assign o_z.zq = (r_state == S_IDLE) ? ZW'(r_res) : r_zq;

endmodule
`default_nettype wire

// ----- hw/rtl/wilson_score_lower_bound.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// wilson_score_lower_bound
// Wilson score interval lower bound, unsigned Q1.FRAC_BITS, fully pipelined.
// ----------------------------------------------------------------------------
// Usage:
//   i_in carries (positive_count, total_count) transactions, o_out carries
//   (lower_bound_q16, count_error). A new transaction is taken every cycle
//   while i_in.ready is high. The pipeline holds one quotient bit per stage
//   in the variance divider, one root bit per stage in the 32-stage square
//   root, one fraction bit per stage in the final divider, plus input,
//   multiply, t, z*sqrt, clamp and output registers.
//   i_cfg_we / i_cfg_data write alpha (Q0.16). z is then re-derived by a
//   sequencer, during which i_in.ready is low; the same run follows reset
//   with alpha = 3277. Write alpha only when no transaction is in flight.
//   An output register plus one skid entry sit at o_out; when the receiver
//   stalls the skid entry fills and the whole pipeline then holds, so
//   nothing is dropped or repeated. Reset empties the pipeline.
// ----------------------------------------------------------------------------
module wilson_score_lower_bound
    import wsl_pkg::*;
#(
    parameter int COUNT_BITS = COUNT_BITS_DEF,
    parameter int FRAC_BITS  = FRAC_BITS_DEF
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cfg_we,
    input  wire logic [15:0] i_cfg_data,
    wsl_in_if.sink           i_in,
    wsl_out_if.source        o_out
);

    localparam int CB       = COUNT_BITS;
    localparam int FB       = FRAC_BITS;
    localparam int QW       = CB + Z_FRAC;
    localparam int TW       = QW + 1;
    localparam int NW       = CB + Z_FRAC + 1;
    localparam int SQ_SHIFT = 2 * ((40 - CB) / 2);
    localparam int SQ_FRAC  = 12 + SQ_SHIFT / 2;
    localparam int RT_STEPS = 32;

    typedef struct packed {
        logic          vld;
        logic          err;
        logic          zero;
        logic          sat;
        logic [CB-1:0] pos;
        logic [CB-1:0] n;
    } t_side;

    t_z_info z;

    wsl_z_gen u_z_gen (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_data (i_cfg_data),
        .o_z        (z)
    );

    logic r_skid_v;
    logic en;

    assign en         = !r_skid_v;
    assign i_in.ready = en && z.ok;

    // input and variance product
    t_side           r_s0;
    logic [CB-1:0]   r_s0_diff;
    t_side           r_s1;
    logic [2*CB-1:0] r_s1_prod;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s0.vld <= 1'b0;
            r_s1.vld <= 1'b0;
        end else if (en) begin
            r_s0.vld  <= i_in.valid && i_in.ready;
            r_s0.err  <= i_in.positive_count > i_in.total_count;
            r_s0.zero <= (i_in.positive_count > i_in.total_count) ||
                         (i_in.total_count == '0);
            r_s0.sat  <= 1'b0;
            r_s0.pos  <= i_in.positive_count;
            r_s0.n    <= i_in.total_count;
            r_s0_diff <= i_in.total_count - i_in.positive_count;
            r_s1      <= r_s0;
            r_s1_prod <= (2*CB)'(r_s0.pos) * (2*CB)'(r_s0_diff);
        end
    end

    // prod * 2^24 / n, one quotient bit per stage
    t_side         r_da_side [QW];
    logic [CB-1:0] r_da_rem  [QW];
    logic [QW-1:0] r_da_acc  [QW];

    for (genvar k = 0; k < QW; k++) begin : g_da
        t_side         side_i;
        logic [CB-1:0] rem_i;
        logic [QW-1:0] acc_i;
        logic [CB:0]   r2;
        logic          ge;

        if (k == 0) begin : g_first
            assign side_i = r_s1;
            assign rem_i  = r_s1_prod[2*CB-1:CB];
            assign acc_i  = {r_s1_prod[CB-1:0], Z_FRAC'(0)};
        end else begin : g_next
            assign side_i = r_da_side[k-1];
            assign rem_i  = r_da_rem[k-1];
            assign acc_i  = r_da_acc[k-1];
        end

        always_comb begin
            r2 = {rem_i, acc_i[QW-1]};
            ge = r2 >= {1'b0, side_i.n};
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_da_side[k].vld <= 1'b0;
            end else if (en) begin
                r_da_side[k] <= side_i;
                r_da_rem[k]  <= ge ? CB'(r2 - {1'b0, side_i.n}) : r2[CB-1:0];
                r_da_acc[k]  <= {acc_i[QW-2:0], ge};
            end
        end
    end

    // t = s + z^2/4
    t_side         r_st;
    logic [TW-1:0] r_st_t;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st.vld <= 1'b0;
        end else if (en) begin
            r_st   <= r_da_side[QW-1];
            r_st_t <= TW'(r_da_acc[QW-1]) + TW'(z.z2 >> 2);
        end
    end

    // square root of t << SQ_SHIFT, one result bit per stage
    t_side       r_rt_side [RT_STEPS];
    logic [63:0] r_rt_v    [RT_STEPS];
    logic [63:0] r_rt_res  [RT_STEPS];

    for (genvar j = 0; j < RT_STEPS; j++) begin : g_rt
        localparam logic [63:0] BIT = 64'd1 << (62 - 2 * j);
        t_side       side_i;
        logic [63:0] v_i;
        logic [63:0] res_i;
        logic [63:0] sum;

        if (j == 0) begin : g_first
            assign side_i = r_st;
            assign v_i    = {r_st_t[63-SQ_SHIFT:0], SQ_SHIFT'(0)};
            assign res_i  = '0;
        end else begin : g_next
            assign side_i = r_rt_side[j-1];
            assign v_i    = r_rt_v[j-1];
            assign res_i  = r_rt_res[j-1];
        end

        assign sum = res_i + BIT;

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_rt_side[j].vld <= 1'b0;
            end else if (en) begin
                r_rt_side[j] <= side_i;
                if (v_i >= sum) begin
                    r_rt_v[j]   <= v_i - sum;
                    r_rt_res[j] <= (res_i >> 1) + BIT;
                end else begin
                    r_rt_v[j]   <= v_i;
                    r_rt_res[j] <= res_i >> 1;
                end
            end
        end
    end

    // z * sqrt, numerator and denominator
    t_side         r_sm;
    logic [63:0]   r_sm_zsp;
    logic [NW-1:0] r_sm_num;
    logic [NW-1:0] r_sm_den;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sm.vld <= 1'b0;
        end else if (en) begin
            r_sm     <= r_rt_side[RT_STEPS-1];
            r_sm_zsp <= 64'(z.zq) * 64'(r_rt_res[RT_STEPS-1][31:0]);
            r_sm_num <= NW'({r_rt_side[RT_STEPS-1].pos, Z_FRAC'(0)}) + NW'(z.z2 >> 1);
            r_sm_den <= NW'({r_rt_side[RT_STEPS-1].n, Z_FRAC'(0)}) + NW'(z.z2);
        end
    end

    logic [63:0]   zs;
    logic [NW-1:0] num_c;
    t_side         sm_c;

    always_comb begin
        zs    = r_sm_zsp >> SQ_FRAC;
        // rounding can push the numerator below zero: clamp
        num_c = (64'(r_sm_num) > zs) ? NW'(64'(r_sm_num) - zs) : '0;
        sm_c     = r_sm;
        sm_c.sat = num_c >= r_sm_den;
    end

    t_side         r_sn;
    logic [NW-1:0] r_sn_num;
    logic [NW-1:0] r_sn_den;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sn.vld <= 1'b0;
        end else if (en) begin
            r_sn     <= sm_c;
            r_sn_num <= num_c;
            r_sn_den <= r_sm_den;
        end
    end

    // fraction bits of num / den, one per stage
    t_side         r_db_side [FB];
    logic [NW-1:0] r_db_rem  [FB];
    logic [NW-1:0] r_db_den  [FB];
    logic [FB-1:0] r_db_f    [FB];

    for (genvar k = 0; k < FB; k++) begin : g_db
        t_side         side_i;
        logic [NW-1:0] rem_i;
        logic [NW-1:0] den_i;
        logic [FB-1:0] f_i;
        logic [NW:0]   r2;
        logic          ge;

        if (k == 0) begin : g_first
            assign side_i = r_sn;
            assign rem_i  = r_sn_num;
            assign den_i  = r_sn_den;
            assign f_i    = '0;
        end else begin : g_next
            assign side_i = r_db_side[k-1];
            assign rem_i  = r_db_rem[k-1];
            assign den_i  = r_db_den[k-1];
            assign f_i    = r_db_f[k-1];
        end

        always_comb begin
            r2 = {rem_i, 1'b0};
            ge = r2 >= {1'b0, den_i};
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_db_side[k].vld <= 1'b0;
            end else if (en) begin
                r_db_side[k] <= side_i;
                r_db_den[k]  <= den_i;
                r_db_rem[k]  <= ge ? NW'(r2 - {1'b0, den_i}) : r2[NW-1:0];
                r_db_f[k]    <= {f_i[FB-2:0], ge};
            end
        end
    end

    t_side       last;
    logic [FB:0] lb_c;

    always_comb begin
        last = r_db_side[FB-1];
        if (last.zero)     lb_c = '0;
        else if (last.sat) lb_c = (FB+1)'(1) << FB;
        else               lb_c = {1'b0, r_db_f[FB-1]};
    end

    // output register with one skid entry
    logic        r_out_v;
    logic [FB:0] r_out_lb;
    logic        r_out_err;
    logic [FB:0] r_skid_lb;
    logic        r_skid_err;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v  <= 1'b0;
            r_skid_v <= 1'b0;
        end else if (r_skid_v) begin
            if (o_out.ready) begin
                r_out_lb  <= r_skid_lb;
                r_out_err <= r_skid_err;
                r_skid_v  <= 1'b0;
            end
        end else if (r_out_v && !o_out.ready) begin
            if (last.vld) begin
                r_skid_lb  <= lb_c;
                r_skid_err <= last.err;
                r_skid_v   <= 1'b1;
            end
        end else begin
            r_out_v   <= last.vld;
            r_out_lb  <= lb_c;
            r_out_err <= last.err;
        end
    end

    assign o_out.valid           = r_out_v;
    assign o_out.lower_bound_q16 = r_out_lb;
    assign o_out.count_error     = r_out_err;

endmodule
`default_nettype wire

// ----- hw/rtl/wsl_checker.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// wsl_checker
// Port-level checks on the Wilson lower bound block, bound to the top.
// ----------------------------------------------------------------------------
module wsl_checker
    import wsl_pkg::*;
#(
    parameter int FRAC_BITS = FRAC_BITS_DEF
) (
    input wire logic             i_clk,
    input wire logic             i_rst_n,
    input wire logic             i_cfg_we,
    input wire logic             i_in_ready,
    input wire logic             i_out_valid,
    input wire logic             i_out_ready,
    input wire logic [FRAC_BITS:0] i_out_lb,
    input wire logic             i_out_err
);

    // a held result transaction keeps its payload
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_out_lb) &&
        $stable(i_out_err))
        else $error("output changed while stalled");

    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_out_err |-> i_out_lb == '0)
        else $error("count error with nonzero bound");

    a_bound_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> i_out_lb <= ((FRAC_BITS+1)'(1) << FRAC_BITS))
        else $error("bound above one");

    // z re-derivation blocks input after an alpha write
    a_cfg_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cfg_we |=> !i_in_ready)
        else $error("input taken while z is re-derived");

    a_rst_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("output valid right after reset");

endmodule

bind wilson_score_lower_bound wsl_checker #(.FRAC_BITS(FRAC_BITS)) u_wsl_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_cfg_we    (i_cfg_we),
    .i_in_ready  (i_in.ready),
    .i_out_valid (o_out.valid),
    .i_out_ready (o_out.ready),
    .i_out_lb    (o_out.lower_bound_q16),
    .i_out_err   (o_out.count_error)
);
`default_nettype wire
